[hw/rtl/wsfd_pkg.sv]
// Shared types and codes for the WebSocket frame decoder.
// No dependencies; imported by every module of the block.
package wsfd_pkg;

	localparam int LenW = 64;
	localparam int MaxW = 63;
	localparam int KeyW = 32;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONFINAL = 3'd0;
	localparam logic [2:0] ERR_BAD_OP   = 3'd1;
	localparam logic [2:0] ERR_MASK     = 3'd2;
	localparam logic [2:0] ERR_ZERO_BIN = 3'd3;
	localparam logic [2:0] ERR_OVERSIZE = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_MUST_MASK  = 2'd0;
	localparam logic [1:0] REG_LIMIT_ON   = 2'd1;
	localparam logic [1:0] REG_MAX_SIZE   = 2'd2;

	// opcodes (low nibble of first header byte)
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [6:0] LEN_EXT16 = 7'd126;

	// message flag bits
	localparam int MF_MORE    = 0;
	localparam int MF_COMMAND = 1;
	localparam int MF_CLOSE   = 2;
	localparam int MF_PING    = 3;
	localparam int MF_PONG    = 4;

	typedef enum logic [7:0] {
		PH_OPCODE  = 8'b0000_0001,
		PH_LEN1    = 8'b0000_0010,
		PH_LEN16   = 8'b0000_0100,
		PH_LEN64   = 8'b0000_1000,
		PH_MASK    = 8'b0001_0000,
		PH_FLAGS   = 8'b0010_0000,
		PH_PAYLOAD = 8'b0100_0000,
		PH_HALT    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [4:0] flags;
		logic       last;
		logic [2:0] err;
	} result_t;

	typedef struct packed {
		logic            must_mask;
		logic            limit_on;
		logic [LenW-1:0] max_size;     // zero-extended limit
		logic [LenW-1:0] max_size_p1;  // limit + 1, used when the flags byte is removed
	} cfg_t;

endpackage

[hw/rtl/wsfd_parse.sv]
// Frame header parser and payload unmasker: one stream byte per request.
// Depends on wsfd_pkg.
module wsfd_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       stream_byte,
	input  wsfd_pkg::cfg_t   cfg,
	output logic             res_valid,
	output wsfd_pkg::result_t res
);
	import wsfd_pkg::*;

	phase_t          phase_q, phase_n;
	logic            binary_q, binary_n;
	logic [4:0]      flags_q, flags_n;
	logic [LenW-1:0] rem_q, rem_n;
	logic [2:0]      hcnt_q, hcnt_n;
	logic [KeyW-1:0] key_q, key_n;
	logic [1:0]      mpos_q, mpos_n;

	logic [LenW-1:0] len_new, lim;
	logic            over, zero_len;
	logic [1:0]      kpos;
	logic [7:0]      kbyte, ub;

	function automatic logic [7:0] key_byte(logic [KeyW-1:0] key, logic [1:0] pos);
		logic [7:0] r;
		case (pos)
			2'd0:    r = key[31:24];
			2'd1:    r = key[23:16];
			2'd2:    r = key[15:8];
			default: r = key[7:0];
		endcase
		return r;
	endfunction

	always_comb begin
		case (phase_q)
			PH_LEN1:           len_new = {{(LenW-7){1'b0}}, stream_byte[6:0]};
			PH_LEN16, PH_LEN64: len_new = {rem_q[LenW-9:0], stream_byte};
			default:           len_new = rem_q;
		endcase
	end

	// flags byte is removed from the length: rem-1 > max  <=>  rem > max+1
	assign lim      = (phase_q == PH_FLAGS) ? cfg.max_size_p1 : cfg.max_size;
	assign over     = cfg.limit_on && (len_new > lim);
	assign zero_len = (phase_q == PH_FLAGS) ? (rem_q == LenW'(1)) : (len_new == '0);

	assign kpos  = (phase_q == PH_FLAGS) ? 2'd0 : mpos_q;
	assign kbyte = key_byte(key_q, kpos);
	assign ub    = cfg.must_mask ? (stream_byte ^ kbyte) : stream_byte;

	always_comb begin
		logic fail, after_len, after_key, len_done;
		logic [2:0] code;
		fail      = 1'b0;
		after_len = 1'b0;
		after_key = 1'b0;
		len_done  = 1'b0;
		code      = ERR_NONFINAL;
		phase_n   = phase_q;
		binary_n  = binary_q;
		flags_n   = flags_q;
		rem_n     = rem_q;
		hcnt_n    = hcnt_q;
		key_n     = key_q;
		mpos_n    = mpos_q;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_OPCODE: begin
				if (!stream_byte[7]) begin
					fail = 1'b1;
					code = ERR_NONFINAL;
				end else begin
					binary_n = 1'b0;
					phase_n  = PH_LEN1;
					case (stream_byte[3:0])
						OP_BINARY: begin
							flags_n  = '0;
							binary_n = 1'b1;
						end
						OP_CLOSE: flags_n = 5'(1 << MF_COMMAND) | 5'(1 << MF_CLOSE);
						OP_PING:  flags_n = 5'(1 << MF_COMMAND) | 5'(1 << MF_PING);
						OP_PONG:  flags_n = 5'(1 << MF_COMMAND) | 5'(1 << MF_PONG);
						default: begin
							flags_n = '0;
							fail    = 1'b1;
							code    = ERR_BAD_OP;
						end
					endcase
				end
			end
			PH_LEN1: begin
				if (stream_byte[7] != cfg.must_mask) begin
					fail = 1'b1;
					code = ERR_MASK;
				end else begin
					hcnt_n = '0;
					if (stream_byte[6:0] < LEN_EXT16) begin
						rem_n     = len_new;
						after_len = 1'b1;
					end else begin
						rem_n   = '0;
						phase_n = (stream_byte[6:0] == LEN_EXT16) ? PH_LEN16 : PH_LEN64;
					end
				end
			end
			PH_LEN16, PH_LEN64: begin
				rem_n  = len_new;
				hcnt_n = hcnt_q + 3'd1;
				if ((phase_q == PH_LEN16 && hcnt_n == 3'd2) ||
				    (phase_q == PH_LEN64 && hcnt_n == 3'd0))
					after_len = 1'b1;
			end
			PH_MASK: begin
				key_n  = {key_q[KeyW-9:0], stream_byte};
				hcnt_n = hcnt_q + 3'd1;
				if (hcnt_n == 3'd4) begin
					hcnt_n    = '0;
					mpos_n    = '0;
					after_key = 1'b1;
				end
			end
			PH_FLAGS: begin
				mpos_n              = 2'd1;
				flags_n[MF_MORE]    = flags_q[MF_MORE] | ub[0];
				flags_n[MF_COMMAND] = flags_q[MF_COMMAND] | ub[1];
				rem_n               = rem_q - LenW'(1);
				len_done            = 1'b1;
			end
			PH_PAYLOAD: begin
				mpos_n    = mpos_q + 2'd1;
				rem_n     = rem_q - LenW'(1);
				res_valid = 1'b1;
				res.kind  = KIND_PAYLOAD;
				res.data  = ub;
				res.flags = flags_q;
				res.last  = (rem_q == LenW'(1));
				if (res.last)
					phase_n = PH_OPCODE;
			end
			default: ;  // halted: drop everything
		endcase

		if (after_len) begin
			hcnt_n = '0;
			if (cfg.must_mask) begin
				key_n   = '0;
				phase_n = PH_MASK;
			end else begin
				after_key = 1'b1;
			end
		end

		if (after_key) begin
			if (binary_q) begin
				if (zero_len) begin
					fail = 1'b1;
					code = ERR_ZERO_BIN;
				end else begin
					phase_n = PH_FLAGS;
				end
			end else begin
				len_done = 1'b1;
			end
		end

		if (len_done) begin
			if (over) begin
				fail = 1'b1;
				code = ERR_OVERSIZE;
			end else if (zero_len) begin
				res_valid = 1'b1;
				res.kind  = KIND_EMPTY;
				res.flags = flags_n;
				res.last  = 1'b1;
				phase_n   = PH_OPCODE;
			end else begin
				phase_n = PH_PAYLOAD;
			end
		end

		if (fail) begin
			phase_n   = PH_HALT;
			res_valid = 1'b1;
			res       = '0;
			res.kind  = KIND_ERROR;
			res.err   = code;
		end

		if (!step)
			res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			binary_q <= 1'b0;
			flags_q  <= '0;
			rem_q    <= '0;
			hcnt_q   <= '0;
			key_q    <= '0;
			mpos_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			binary_q <= binary_n;
			flags_q  <= flags_n;
			rem_q    <= rem_n;
			hcnt_q   <= hcnt_n;
			key_q    <= key_n;
			mpos_q   <= mpos_n;
		end
	end

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |-> !res_valid)
		else $error("result produced after error halt");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_ERROR |=> phase_q == PH_HALT)
		else $error("error result did not halt parser");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with zero remaining length");

endmodule

[hw/rtl/wsfd_out_buf.sv]
// Two-entry output register with skid stage for decoder results.
// Depends on wsfd_pkg.
module wsfd_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsfd_pkg::result_t push_res,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output wsfd_pkg::result_t out_res
);
	import wsfd_pkg::*;

	logic    out_v_q, skid_v_q;
	result_t out_q, skid_q;
	logic    pop;

	assign pop       = out_v_q && out_ready;
	assign space     = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (!out_v_q)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (push)
				out_q <= push_res;
		end else if (push) begin
			if (!out_v_q)
				out_q <= push_res;
			else
				skid_q <= push_res;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !out_ready && push))
		else $error("skid filled without a stalled output");

endmodule

[hw/rtl/websocket_frame_decoder.sv]
// WebSocket frame decoder: byte-serial parser for single-fragment frames.
// A result is registered into the output buffer when its byte request is accepted.
// Throughput: one byte per cycle while the skid slot is free; header logic and unmask
//   sit between the input port and the two-entry output buffer.
// Reset (arst_n low): parser waits for an opcode byte, registers clear to zero (max+1 to
//   one), output buffer empties. An error halts the parser until the next reset.
module websocket_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// byte request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic        has_more,
	output logic        is_command,
	output logic        close_flag,
	output logic        ping_flag,
	output logic        pong_flag,
	output logic        last_of_message,
	output logic [2:0]  error_code,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [wsfd_pkg::MaxW-1:0] cfg_data
);
	import wsfd_pkg::*;

	// configuration registers; max+1 is kept alongside the limit so the
	// flags-byte case compares without a subtract in front of it
	logic            must_mask_q;
	logic            limit_on_q;
	logic [MaxW-1:0] max_size_q;
	logic [LenW-1:0] max_size_p1_q;
	cfg_t            cfg;

	logic    step;
	logic    res_valid;
	result_t res, out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			must_mask_q   <= 1'b0;
			limit_on_q    <= 1'b0;
			max_size_q    <= '0;
			max_size_p1_q <= LenW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MUST_MASK: must_mask_q <= cfg_data[0];
				REG_LIMIT_ON:  limit_on_q  <= cfg_data[0];
				REG_MAX_SIZE: begin
					max_size_q    <= cfg_data;
					max_size_p1_q <= {1'b0, cfg_data} + LenW'(1);
				end
				default: ;  // unknown index: ignored
			endcase
		end
	end

	assign cfg.must_mask   = must_mask_q;
	assign cfg.limit_on    = limit_on_q;
	assign cfg.max_size    = {1'b0, max_size_q};
	assign cfg.max_size_p1 = max_size_p1_q;

	// a byte is taken whenever the skid slot is free, even if a result waits
	assign step = in_valid && in_ready;

	wsfd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.stream_byte (stream_byte),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res         (res)
	);

	wsfd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign result_kind     = out_res.kind;
	assign payload_byte    = out_res.data;
	assign has_more        = out_res.flags[MF_MORE];
	assign is_command      = out_res.flags[MF_COMMAND];
	assign close_flag      = out_res.flags[MF_CLOSE];
	assign ping_flag       = out_res.flags[MF_PING];
	assign pong_flag       = out_res.flags[MF_PONG];
	assign last_of_message = out_res.last;
	assign error_code      = out_res.err;

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_ERROR |->
			out_res.flags == '0 && !last_of_message && payload_byte == '0)
		else $error("error result carries message fields");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_ready)
		else $error("result produced with no buffer space");

endmodule
